// ----- rtl/core/tcw_pkg.sv -----
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int CELL_W = CHAR_W + ATTR_W;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;

  typedef enum logic [1:0] {
    OP_PUT        = 2'd0,
    OP_CLEAR      = 2'd1,
    OP_SET_CURSOR = 2'd2,
    OP_READ       = 2'd3
  } op_t;

  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

  localparam logic [CELL_W-1:0] RESET_CELL = 16'h0720;
  localparam logic [ATTR_W-1:0] RESET_COLOR = 8'h07;

  localparam int TAB_STEP = 8;

  // configuration register indexes
  localparam logic REG_TEXT_COLOR  = 1'b0;
  localparam logic REG_TEXT_ENABLE = 1'b1;

endpackage

// ----- rtl/core/text_console_writer_core.sv -----
`timescale 1ns / 1ps

// Text console engine: a COLUMNS x ROWS screen of 16-bit cells (character in
// the low byte, attribute in the high byte) held in one block RAM, plus a cursor.
//
// Channels:
//   s_* : operation words (put character, clear, set cursor, read cell).
//   m_* : one result word per operation: cursor after the operation, and the
//         cell contents for an in-range read.
//   cfg_*: register writes (index 0 text_color, index 1 text_enable); always
//          ready, write only while no operation is in flight.
//
// Flow: s_tready returns with the result, so one operation is in work at a
// time. A put that scrolls copies every row but the top one up a row, then
// blanks the bottom row; clear blanks every cell; backspace at column zero
// scans the row above cell by cell from its last column. All of this work
// goes through the single RAM port pair.
// Reset: a clearing pass fills the screen with 0x0720; s_tready stays low
// until it ends. A stalled result holds in the output register; the next
// word finishing waits in its output state until it is taken.

module text_console_writer_core
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                  clk,
  input  logic                  rst,
  // opcode[1:0], char_code[9:2], pos_x[16:10], pos_y[21:17], zero pad
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // cursor_column[6:0], cursor_line[11:7], cell_word[27:12], cell_ok[28], pad
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [ATTR_W-1:0]     cfg_data
);

  localparam int CELLS   = COLUMNS * ROWS;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int SWEEP_W = $clog2(CELLS + 1);

  localparam logic [COL_W-1:0]   COL_LAST  = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0]   ROW_LAST  = ROW_W'(ROWS - 1);
  localparam logic [SWEEP_W-1:0] SW_CELLS  = SWEEP_W'(CELLS);
  localparam logic [SWEEP_W-1:0] SW_LAST   = SWEEP_W'(CELLS - 1);
  localparam logic [SWEEP_W-1:0] SW_COLS   = SWEEP_W'(COLUMNS);
  localparam logic [SWEEP_W-1:0] SW_BOTTOM = SWEEP_W'(CELLS - COLUMNS);
  localparam logic [ADDR_W-1:0]  ADDR_COLS = ADDR_W'(COLUMNS);

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_SCROLL,
    S_FILL,
    S_BS_RD,
    S_BS_CHK,
    S_RD_DATA,
    S_OUT
  } state_t;

  state_t state;

  // registers
  logic [ATTR_W-1:0]  text_color;
  logic               text_enable;
  logic [COL_W-1:0]   cur_col;
  logic [ROW_W-1:0]   cur_row;
  op_t                op;
  logic [CHAR_W-1:0]  ch;
  logic [COL_W-1:0]   px;
  logic [ROW_W-1:0]   py;
  logic [SWEEP_W-1:0] sweep;
  logic               pend;
  logic [ADDR_W-1:0]  scroll_wa;
  logic [CELL_W-1:0]  res_word;
  logic               res_ok;

  // RAM port
  logic              ram_we;
  logic [ADDR_W-1:0] ram_wa;
  logic [CELL_W-1:0] ram_wd;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_ra;
  logic [CELL_W-1:0] ram_rd;

  logic [CELL_W-1:0] blank;
  logic [COL_W:0]    tab_col;
  logic [COL_W:0]    adv_col;
  logic              printable;
  logic              line_feed;
  logic              pos_ok;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    cell_addr = ADDR_W'(ADDR_W'(r) * ADDR_COLS + ADDR_W'(c));
  endfunction

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .rd_en   (ram_re),
    .rd_addr (ram_ra),
    .rd_data (ram_rd)
  );

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  assign blank   = {text_color, CH_SPACE};
  // next tab stop and next column, one bit wider to see the wrap
  assign tab_col = ({1'b0, cur_col} + (COL_W + 1)'(TAB_STEP)) &
                   ~(COL_W + 1)'(TAB_STEP - 1);
  assign adv_col = {1'b0, cur_col} + 1'b1;
  assign pos_ok  = (px < COL_W'(COLUMNS)) && (py < ROW_W'(ROWS));

  always_comb begin
    printable = 1'b0;
    line_feed = 1'b0;
    case (ch) inside
      CH_NEWLINE:   line_feed = 1'b1;
      CH_TAB:       line_feed = (tab_col >= (COL_W + 1)'(COLUMNS));
      CH_RETURN,
      CH_BACKSPACE: line_feed = 1'b0;
      default: begin
        printable = 1'b1;
        line_feed = (adv_col >= (COL_W + 1)'(COLUMNS));
      end
    endcase
  end

  // RAM address and write data per state
  always_comb begin
    ram_we = 1'b0;
    ram_wa = sweep[ADDR_W-1:0];
    ram_wd = blank;
    ram_re = 1'b0;
    ram_ra = sweep[ADDR_W-1:0];
    unique case (state)
      S_INIT: begin
        ram_we = 1'b1;
        ram_wd = RESET_CELL;
      end
      S_FILL: begin
        ram_we = 1'b1;
      end
      S_SCROLL: begin
        ram_re = (sweep < SW_CELLS);
        ram_we = pend;
        ram_wa = scroll_wa;
        ram_wd = ram_rd;
      end
      S_EXEC: begin
        if (op == OP_PUT && text_enable) begin
          if (ch == CH_BACKSPACE && cur_col != '0) begin
            ram_we = 1'b1;
            ram_wa = cell_addr(cur_row, cur_col - 1'b1);
          end else if (printable) begin
            ram_we = 1'b1;
            ram_wa = cell_addr(cur_row, cur_col);
            ram_wd = {text_color, ch};
          end
        end
        if (op == OP_READ && pos_ok) begin
          ram_re = 1'b1;
          ram_ra = cell_addr(py, px);
        end
      end
      S_BS_RD: begin
        ram_re = 1'b1;
        ram_ra = cell_addr(cur_row, cur_col);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_INIT;
      text_color  <= RESET_COLOR;
      text_enable <= 1'b1;
      cur_col     <= '0;
      cur_row     <= '0;
      sweep       <= '0;
      pend        <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_TEXT_COLOR) begin
          text_color <= cfg_data;
        end else begin
          text_enable <= cfg_data[0];
        end
      end

      // drop the result once taken; a new one loaded below overrides
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_INIT: begin
          if (sweep == SW_LAST) begin
            state <= S_IDLE;
          end else begin
            sweep <= sweep + 1'b1;
          end
        end

        S_IDLE: begin
          if (s_tvalid) begin
            op    <= op_t'(s_tdata[1:0]);
            ch    <= s_tdata[9:2];
            px    <= s_tdata[16:10];
            py    <= s_tdata[21:17];
            state <= S_EXEC;
          end
        end

        S_EXEC: begin
          res_word <= '0;
          res_ok   <= 1'b0;
          state    <= S_OUT;
          unique case (op)
            OP_PUT: begin
              if (text_enable) begin
                case (ch)
                  CH_NEWLINE: ;
                  CH_RETURN: cur_col <= '0;
                  CH_BACKSPACE: begin
                    if (cur_col != '0) begin
                      cur_col <= cur_col - 1'b1;
                    end else if (cur_row != '0) begin
                      // scan the row above from its last column down
                      cur_row <= cur_row - 1'b1;
                      cur_col <= COL_LAST;
                      state   <= S_BS_RD;
                    end
                  end
                  CH_TAB:  cur_col <= tab_col[COL_W-1:0];
                  default: cur_col <= adv_col[COL_W-1:0];
                endcase
                if (line_feed) begin
                  cur_col <= '0;
                  if (cur_row == ROW_LAST) begin
                    sweep <= SW_COLS;
                    pend  <= 1'b0;
                    state <= S_SCROLL;
                  end else begin
                    cur_row <= cur_row + 1'b1;
                  end
                end
              end
            end
            OP_CLEAR: begin
              if (text_enable) begin
                cur_col <= '0;
                cur_row <= '0;
                sweep   <= '0;
                state   <= S_FILL;
              end
            end
            OP_SET_CURSOR: begin
              if (pos_ok) begin
                cur_col <= px;
                cur_row <= py;
              end
            end
            OP_READ: begin
              if (pos_ok) begin
                state <= S_RD_DATA;
              end
            end
          endcase
        end

        S_SCROLL: begin
          // read one row ahead, write the word back one row up next cycle
          pend      <= (sweep < SW_CELLS);
          scroll_wa <= ADDR_W'(sweep - SW_COLS);
          if (sweep < SW_CELLS) begin
            sweep <= sweep + 1'b1;
          end else begin
            sweep <= SW_BOTTOM;
            state <= S_FILL;
          end
        end

        S_FILL: begin
          if (sweep == SW_LAST) begin
            state <= S_OUT;
          end else begin
            sweep <= sweep + 1'b1;
          end
        end

        S_BS_RD: state <= S_BS_CHK;

        S_BS_CHK: begin
          if (ram_rd[CHAR_W-1:0] != CH_SPACE) begin
            // column after the last character, held inside the row
            cur_col <= (cur_col == COL_LAST) ? COL_LAST : cur_col + 1'b1;
            state   <= S_OUT;
          end else begin
            cur_col <= cur_col - 1'b1;
            state   <= (cur_col == COL_W'(1)) ? S_OUT : S_BS_RD;
          end
        end

        S_RD_DATA: begin
          res_word <= ram_rd;
          res_ok   <= 1'b1;
          state    <= S_OUT;
        end

        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {3'b000, res_ok, res_word, cur_row, cur_col};
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (cur_col < COL_W'(COLUMNS)) && (cur_row < ROW_W'(ROWS)))
    else $error("cursor outside the screen");

  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re && (ram_wa == ram_ra)))
    else $error("RAM read and write hit the same cell");

  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_OUT))
    else $error("result raised outside the output state");
`endif

endmodule

// ----- rtl/core/tcw_ram.sv -----
`timescale 1ns / 1ps

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import tcw_pkg::*;

  localparam int SCR_COLS = 80;
  localparam int SCR_ROWS = 25;
  localparam int SCR_CELLS = SCR_COLS * SCR_ROWS;

  // Cursor and cell read that the block must report for one operation word.
  typedef struct packed {
    logic [COL_W-1:0]  cursor_column;
    logic [ROW_W-1:0]  cursor_line;
    logic [CELL_W-1:0] cell_word;
    logic              cell_ok;
  } status_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  // opcode[1:0], char_code[9:2], pos_x[16:10], pos_y[21:17], zero pad
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // cursor_column[6:0], cursor_line[11:7], cell_word[27:12], cell_ok[28], pad
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic                  cfg_index = REG_TEXT_COLOR;
  logic [ATTR_W-1:0]     cfg_data = '0;

  // Shadow of the console: screen, cursor and the two registers.
  logic [CELL_W-1:0] screen_q [SCR_CELLS];
  int                col_q;
  int                row_q;
  logic [ATTR_W-1:0] attr_q;
  logic              text_on;

  // Status words still owed by the block, oldest first.
  status_t console_status_q [$];
  int      fail_count = 0;

  // Drop idling on one side for a stretch when set.
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;

  text_console_writer_core #(
    .COLUMNS(SCR_COLS),
    .ROWS   (SCR_ROWS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Move the cursor to the start of the next row; running off the bottom
  // shifts every row up and blanks the last one in the current color.
  function automatic void next_row();
    int k;
    col_q = 0;
    row_q++;
    if (row_q >= SCR_ROWS) begin
      for (k = 0; k < SCR_CELLS - SCR_COLS; k++)
        screen_q[k] = screen_q[k + SCR_COLS];
      for (k = SCR_CELLS - SCR_COLS; k < SCR_CELLS; k++)
        screen_q[k] = {attr_q, CH_SPACE};
      row_q = SCR_ROWS - 1;
      col_q = 0;
    end
  endfunction

  // Apply one operation to the shadow console and return the status word.
  function automatic status_t console_apply(op_t op, logic [CHAR_W-1:0] ch,
                                            logic [COL_W-1:0] px, logic [ROW_W-1:0] py);
    status_t st;
    int      k;
    st = '0;
    case (op)
      OP_PUT: if (text_on) begin
        case (ch)
          CH_NEWLINE: next_row();
          CH_RETURN: col_q = 0;
          CH_BACKSPACE: begin
            if (col_q > 0) begin
              col_q--;
              screen_q[row_q * SCR_COLS + col_q] = {attr_q, CH_SPACE};
            end else if (row_q > 0) begin
              // Land just past the last non-blank character of the row above.
              row_q--;
              col_q = SCR_COLS - 1;
              while (col_q > 0) begin
                if (screen_q[row_q * SCR_COLS + col_q][CHAR_W-1:0] != CH_SPACE) begin
                  col_q++;
                  break;
                end
                col_q--;
              end
              if (col_q > SCR_COLS - 1) col_q = SCR_COLS - 1;
            end
          end
          CH_TAB: begin
            col_q = (col_q + TAB_STEP) / TAB_STEP * TAB_STEP;
            if (col_q >= SCR_COLS) next_row();
          end
          default: begin
            screen_q[row_q * SCR_COLS + col_q] = {attr_q, ch};
            col_q++;
            if (col_q >= SCR_COLS) next_row();
          end
        endcase
      end
      OP_CLEAR: if (text_on) begin
        for (k = 0; k < SCR_CELLS; k++) screen_q[k] = {attr_q, CH_SPACE};
        col_q = 0;
        row_q = 0;
      end
      OP_SET_CURSOR: if (px < SCR_COLS && py < SCR_ROWS) begin
        col_q = int'(px);
        row_q = int'(py);
      end
      OP_READ: if (px < SCR_COLS && py < SCR_ROWS) begin
        st.cell_word = screen_q[int'(py) * SCR_COLS + int'(px)];
        st.cell_ok   = 1'b1;
      end
    endcase
    st.cursor_column = COL_W'(col_q);
    st.cursor_line   = ROW_W'(row_q);
    return st;
  endfunction

  // Send one operation word. Enter and leave at a falling edge; tvalid stays
  // high on return so back-to-back words need no extra assignment.
  task automatic push_op(input op_t op, input logic [CHAR_W-1:0] ch,
                         input logic [COL_W-1:0] px, input logic [ROW_W-1:0] py);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  <= {{(IN_DATA_W - 22){1'b0}}, py, px, ch, op};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (s_tready !== 1'b1);
    console_status_q.push_back(console_apply(op, ch, px, py));
    @(negedge clk);
  endtask

  // Drop tvalid and return at a falling edge.
  task automatic quiet_sender;
    s_tvalid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained;
    while (console_status_q.size() != 0) @(negedge clk);
  endtask

  // Hold the sender until the block is idle, then write one register.
  task automatic program_reg(input logic idx, input logic [ATTR_W-1:0] val);
    quiet_sender;
    wait_drained;
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx == REG_TEXT_COLOR) attr_q = val;
    else text_on = val[0];
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Random console traffic: mostly text with control characters mixed in,
  // some cursor moves and cell reads, rare clears. Fields an operation
  // ignores still carry random bits.
  task automatic random_traffic(input int count);
    int            n;
    int            pick;
    int            sel;
    op_t           op;
    logic [CHAR_W-1:0] ch;
    logic [COL_W-1:0]  px;
    logic [ROW_W-1:0]  py;
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      ch   = CHAR_W'($urandom_range(0, 255));
      px   = COL_W'($urandom_range(0, 127));
      py   = ROW_W'($urandom_range(0, 31));
      if (pick < 1) begin
        op = OP_CLEAR;
      end else if (pick < 9) begin
        op = OP_SET_CURSOR;
        if ($urandom_range(0, 3) != 0) begin
          px = COL_W'($urandom_range(0, SCR_COLS - 1));
          py = ROW_W'($urandom_range(0, SCR_ROWS - 1));
        end
      end else if (pick < 19) begin
        op = OP_READ;
        if ($urandom_range(0, 3) != 0) begin
          px = COL_W'($urandom_range(0, SCR_COLS - 1));
          // Favor the cursor row so fresh writes get read back.
          py = $urandom_range(0, 1) ? ROW_W'(row_q)
                                    : ROW_W'($urandom_range(0, SCR_ROWS - 1));
        end
      end else begin
        op  = OP_PUT;
        sel = $urandom_range(0, 99);
        if (sel < 6) ch = CH_NEWLINE;
        else if (sel < 10) ch = CH_RETURN;
        else if (sel < 22) ch = CH_BACKSPACE;
        else if (sel < 30) ch = CH_TAB;
        else if (sel < 45) ch = CH_SPACE;
      end
      push_op(op, ch, px, py);
      // Now and then hold the sender until every status word is back.
      if ($urandom_range(0, 199) == 0) begin
        quiet_sender;
        wait_drained;
      end
    end
  endtask

  // Cursor motion, wrap, scroll, backspace corner cases and position limits.
  task automatic test_directed_layout;
    push_op(OP_READ, 8'h00, 7'd0, 5'd0);              // reset contents
    push_op(OP_READ, 8'hFF, 7'd127, 5'd31);           // far out of range
    push_op(OP_PUT, 8'h00, 7'd0, 5'd0);               // lowest byte is printable
    push_op(OP_PUT, 8'hFF, 7'd127, 5'd31);
    push_op(OP_PUT, CH_TAB, 7'd0, 5'd0);
    push_op(OP_PUT, CH_RETURN, 7'd0, 5'd0);
    push_op(OP_SET_CURSOR, 8'h00, 7'd79, 5'd0);
    push_op(OP_PUT, 8'h78, 7'd0, 5'd0);               // last column, wraps
    push_op(OP_PUT, CH_BACKSPACE, 7'd0, 5'd0);        // back up; row above ends in its last column
    push_op(OP_SET_CURSOR, 8'h00, 7'd75, 5'd1);
    push_op(OP_PUT, CH_TAB, 7'd0, 5'd0);              // tab past the edge
    push_op(OP_PUT, CH_BACKSPACE, 7'd0, 5'd0);        // row above all blank
    push_op(OP_PUT, 8'h63, 7'd0, 5'd0);
    push_op(OP_PUT, 8'h64, 7'd0, 5'd0);
    push_op(OP_SET_CURSOR, 8'h00, 7'd0, 5'd2);
    push_op(OP_PUT, CH_BACKSPACE, 7'd0, 5'd0);        // land after the text
    push_op(OP_PUT, CH_BACKSPACE, 7'd0, 5'd0);        // erase within the row
    push_op(OP_SET_CURSOR, 8'h00, 7'd0, 5'd0);
    push_op(OP_PUT, CH_BACKSPACE, 7'd0, 5'd0);        // home: no motion
    push_op(OP_SET_CURSOR, 8'h00, 7'd80, 5'd0);       // column just too big
    push_op(OP_SET_CURSOR, 8'h00, 7'd0, 5'd25);       // row just too big
    push_op(OP_SET_CURSOR, 8'h00, 7'd0, 5'd24);
    push_op(OP_PUT, CH_NEWLINE, 7'd0, 5'd0);          // scroll
    push_op(OP_READ, 8'h00, 7'd79, 5'd24);
    push_op(OP_CLEAR, 8'h00, 7'd0, 5'd0);
  endtask

  // With text output off, puts and clears leave screen and cursor alone.
  task automatic test_disabled_output;
    program_reg(REG_TEXT_ENABLE, {7'($urandom_range(0, 127)), 1'b0});
    push_op(OP_PUT, 8'h7A, 7'd0, 5'd0);
    push_op(OP_PUT, CH_NEWLINE, 7'd0, 5'd0);
    push_op(OP_CLEAR, 8'h00, 7'd0, 5'd0);
    push_op(OP_SET_CURSOR, 8'h00, 7'd5, 5'd5);
    push_op(OP_READ, 8'h00, 7'd0, 5'd0);
    random_traffic(40);
    program_reg(REG_TEXT_ENABLE, {7'($urandom_range(0, 127)), 1'b1});
  endtask

  // Attribute extremes, then a random one.
  task automatic test_color_sweep;
    program_reg(REG_TEXT_COLOR, 8'hFF);
    random_traffic(150);
    program_reg(REG_TEXT_COLOR, 8'h00);
    random_traffic(150);
    program_reg(REG_TEXT_COLOR, ATTR_W'($urandom_range(0, 255)));
    random_traffic(150);
  endtask

  // Bulk traffic in phases, with idling dropped on one or both sides in some.
  task automatic test_random_text;
    int ph;
    for (ph = 0; ph < 6; ph++) begin
      program_reg(REG_TEXT_COLOR, ATTR_W'($urandom_range(0, 255)));
      tx_quiet = (ph == 1 || ph == 4);
      rx_quiet = (ph == 2 || ph == 4);
      random_traffic(150);
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  // Result side: stall a random number of cycles per word, then take it and
  // compare it with the oldest status word owed.
  initial begin : result_check
    status_t want;
    int      stall;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      stall = rx_quiet ? 0 : $urandom_range(0, 16);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      if (console_status_q.size() == 0) begin
        $error("status word 0x%h with no operation outstanding", m_tdata);
        fail_count++;
      end else begin
        want = console_status_q.pop_front();
        if (m_tdata[6:0] !== want.cursor_column) begin
          $error("cursor_column: expected %0d, got %0d", want.cursor_column, m_tdata[6:0]);
          fail_count++;
        end
        if (m_tdata[11:7] !== want.cursor_line) begin
          $error("cursor_line: expected %0d, got %0d", want.cursor_line, m_tdata[11:7]);
          fail_count++;
        end
        if (m_tdata[27:12] !== want.cell_word) begin
          $error("cell_word: expected 0x%h, got 0x%h", want.cell_word, m_tdata[27:12]);
          fail_count++;
        end
        if (m_tdata[28] !== want.cell_ok) begin
          $error("cell_ok: expected %0d, got %0d", want.cell_ok, m_tdata[28]);
          fail_count++;
        end
      end
    end
  end

  initial begin : main_flow
    int k;
    for (k = 0; k < SCR_CELLS; k++) screen_q[k] = RESET_CELL;
    col_q   = 0;
    row_q   = 0;
    attr_q  = RESET_COLOR;
    text_on = 1'b1;

    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // The block runs its clearing pass first; the handshake absorbs it.
    test_directed_layout;
    test_disabled_output;
    test_color_sweep;
    test_random_text;

    // Let the last words drain, then watch a little longer for strays.
    quiet_sender;
    for (k = 0; k < 50000 && console_status_q.size() != 0; k++) @(negedge clk);
    if (console_status_q.size() != 0) begin
      $error("%0d status words never arrived", console_status_q.size());
      fail_count++;
    end
    repeat (20) @(negedge clk);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  // Watchdog: many times the slowest legal run (every operation a full scroll).
  initial begin : watchdog
    #(200_000_000);
    $display("Verification failed");
    $finish;
  end

endmodule
